// ===== design/dlps_pkg.sv =====
// Shared constants, types and fixed-point helpers for the directional light
// Phong shader. No dependencies.
package dlps_pkg;

  // Component format: signed, CB bits, FB fraction bits (Q2.14 at CB = 16).
  localparam int CB   = 16;
  localparam int FB   = CB - 2;
  localparam int FW   = 48;
  localparam int XW   = (3 * CB > FW) ? 3 * CB : FW;
  localparam int KW   = 8;
  localparam int KMAX = (1 << KW) - 1;
  localparam int HALF = 1 << (FB - 1);
  localparam int ONE  = 1 << FB;

  // Internal widths.
  localparam int NDW  = 2 * CB + 2;     // three-term dot product
  localparam int NDR  = NDW - FB;       // rounded dot product
  localparam int DMW  = CB + NDR - FB;  // md * (N.-D), rounded
  localparam int RSW  = 2 * CB + 6;     // reflection, before rounding
  localparam int RW   = RSW - FB;       // reflection / view components
  localparam int SQW  = 2 * RW;         // sum of squares
  localparam int NSQ  = SQW / 2;        // square root iterations
  localparam int DNW  = RW + FB;        // dividend
  localparam int QW   = FB + 1;         // quotient magnitude
  localparam int SATW = 2 * CB + 8;

  // APB port.
  localparam int AW = 5;
  localparam int DW = 64;

  typedef enum logic [1:0] {
    REG_DIR,
    REG_AMB,
    REG_DIF,
    REG_SPC
  } reg_idx_t;

  typedef logic signed [CB-1:0] comp_t;

  typedef struct packed {
    logic [FW-1:0] amb;
    logic [FW-1:0] dif;
    logic [FW-1:0] ms;
    logic [KW-1:0] k;
    logic          culled;
  } side_t;

  function automatic comp_t comp_of(logic [FW-1:0] f, int i);
    logic [XW-1:0] fx;
    fx = XW'(f);
    return comp_t'(fx[i*CB +: CB]);
  endfunction

  function automatic comp_t sat(logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'((1 << (CB - 1)) - 1);
    lo = -hi - SATW'(1);
    if (v > hi) begin
      return hi[CB-1:0];
    end else if (v < lo) begin
      return lo[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  function automatic logic [FW-1:0] pack3(comp_t a, comp_t b, comp_t c);
    logic [3*CB-1:0] w;
    w = {c, b, a};
    return FW'(w);
  endfunction

endpackage

// ===== design/directional_light_phong_shade.sv =====
// Directional light Phong shader: ambient, diffuse and specular terms per hit.
// Fully pipelined datapath; depends on dlps_pkg.
//
// Usage:
//   Input transaction: drive all fields and pulse start. busy stays low, so a
//   start is taken in every cycle and a new hit point may enter each clock.
//   Result transaction: done is high for one cycle with ambient_out,
//   diffuse_out, specular_out and specular_culled valid in that cycle.
//   Throughput is one hit point per cycle. The depth is set by the specular
//   path: 24 square-root iterations, 15 divider steps and 255 exponent steps,
//   one per stage, plus the capture, setup, multiply/round and output stages.
//   Light registers sit on the APB port at byte addresses 0, 8, 16, 24
//   (direction, ambient, diffuse, specular), 48 bits each in a 64-bit word.
//   Write them only while no transaction is in flight.
//   Reset clears the light registers and every stage valid bit; data
//   registers are not reset. Results cannot be held off by the receiver, so
//   the pipeline never stalls.
//   The power stage runs all items through all 255 steps; steps beyond the
//   item's exponent pass the value through.
module directional_light_phong_shade
  import dlps_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [FW-1:0] surface_normal,
  input  logic [FW-1:0] hit_position,
  input  logic [FW-1:0] ray_origin,
  input  logic [FW-1:0] mat_ambient_rgb,
  input  logic [FW-1:0] mat_diffuse_rgb,
  input  logic [FW-1:0] mat_specular_rgb,
  input  logic [KW-1:0] shine_exponent,
  output logic          done,
  output logic [FW-1:0] ambient_out,
  output logic [FW-1:0] diffuse_out,
  output logic [FW-1:0] specular_out,
  output logic          specular_culled,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready
);

  // ---------------------------------------------------------------------
  // Light registers
  // ---------------------------------------------------------------------
  logic [FW-1:0] light_direction;
  logic [FW-1:0] light_ambient_rgb;
  logic [FW-1:0] light_diffuse_rgb;
  logic [FW-1:0] light_specular_rgb;
  reg_idx_t      reg_idx;
  logic          reg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;  // one transaction per cycle, always
  assign reg_idx = reg_idx_t'(paddr[AW-1:AW-2]);
  assign reg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_direction    <= '0;
      light_ambient_rgb  <= '0;
      light_diffuse_rgb  <= '0;
      light_specular_rgb <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_DIR: light_direction    <= pwdata[FW-1:0];
        REG_AMB: light_ambient_rgb  <= pwdata[FW-1:0];
        REG_DIF: light_diffuse_rgb  <= pwdata[FW-1:0];
        REG_SPC: light_specular_rgb <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIR: prdata = DW'(light_direction);
      REG_AMB: prdata = DW'(light_ambient_rgb);
      REG_DIF: prdata = DW'(light_diffuse_rgb);
      REG_SPC: prdata = DW'(light_specular_rgb);
      default: prdata = '0;
    endcase
  end

  comp_t d_c[3], la_c[3], ld_c[3], ls_c[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = comp_of(light_direction, i);
      la_c[i] = comp_of(light_ambient_rgb, i);
      ld_c[i] = comp_of(light_diffuse_rgb, i);
      ls_c[i] = comp_of(light_specular_rgb, i);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture
  // ---------------------------------------------------------------------
  logic          v0;
  logic [FW-1:0] n_f0, p_f0, o_f0, ma_f0, md_f0, ms_f0;
  logic [KW-1:0] k0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_f0  <= surface_normal;
      p_f0  <= hit_position;
      o_f0  <= ray_origin;
      ma_f0 <= mat_ambient_rgb;
      md_f0 <= mat_diffuse_rgb;
      ms_f0 <= mat_specular_rgb;
      k0    <= shine_exponent;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: componentwise products, P - O
  // ---------------------------------------------------------------------
  comp_t                   n0c[3], ma0c[3];
  logic signed [CB:0]      po0[3];
  logic                    v1;
  logic signed [2*CB-1:0]  amb_p1[3], nd_p1[3];
  logic signed [2*CB+1:0]  po_p1[3];
  logic signed [CB:0]      po1[3];
  comp_t                   n1[3];
  logic [FW-1:0]           md1, ms1;
  logic [KW-1:0]           k1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n0c[i]  = comp_of(n_f0, i);
      ma0c[i] = comp_of(ma_f0, i);
      po0[i]  = (CB+1)'(comp_of(p_f0, i)) - (CB+1)'(comp_of(o_f0, i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      amb_p1[i] <= ma0c[i] * la_c[i];
      nd_p1[i]  <= n0c[i] * d_c[i];
      po_p1[i]  <= po0[i] * n0c[i];
      po1[i]    <= po0[i];
      n1[i]     <= n0c[i];
    end
    md1 <= md_f0;
    ms1 <= ms_f0;
    k1  <= k0;
  end

  // ---------------------------------------------------------------------
  // Stage 2: dot sums, facing tests, ambient term
  // ---------------------------------------------------------------------
  logic signed [NDW-1:0]  dsum, ndx, nd_w, dn_w;
  logic signed [2*CB+2:0] podn;
  logic signed [2*CB-1:0] amb_w[3];
  logic                   v2;
  side_t                  s2;
  logic signed [NDR-1:0]  nd2, dn2;
  comp_t                  n2[3];
  logic signed [CB:0]     po2[3];
  logic [FW-1:0]          md2;

  always_comb begin
    dsum = NDW'(nd_p1[0]) + NDW'(nd_p1[1]) + NDW'(nd_p1[2]);
    ndx  = -dsum;
    nd_w = (ndx + NDW'(HALF)) >>> FB;
    dn_w = (dsum + NDW'(HALF)) >>> FB;
    podn = (2*CB+3)'(po_p1[0]) + (2*CB+3)'(po_p1[1]) + (2*CB+3)'(po_p1[2]);
    for (int i = 0; i < 3; i++) begin
      amb_w[i] = (amb_p1[i] + (2*CB)'(HALF)) >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2.amb    <= pack3(sat(SATW'(amb_w[0])), sat(SATW'(amb_w[1])), sat(SATW'(amb_w[2])));
    s2.dif    <= '0;
    s2.ms     <= ms1;
    s2.k      <= k1;
    // back off when the light is behind the surface or the ray hits the back face
    s2.culled <= ndx[NDW-1] | ~podn[2*CB+2];
    nd2       <= nd_w[NDR-1:0];
    dn2       <= dn_w[NDR-1:0];
    md2       <= md1;
    for (int i = 0; i < 3; i++) begin
      n2[i]  <= n1[i];
      po2[i] <= po1[i];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: Md * (N.-D), N * (D.N)
  // ---------------------------------------------------------------------
  logic                     v3;
  side_t                    s3;
  logic signed [CB+NDR-1:0] mdnd3[3], ndn3[3];
  logic signed [CB:0]       po3[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s3 <= s2;
    for (int i = 0; i < 3; i++) begin
      mdnd3[i] <= comp_of(md2, i) * nd2;
      ndn3[i]  <= n2[i] * dn2;
      po3[i]   <= po2[i];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: round diffuse partial, reflection R, view V = O - P
  // ---------------------------------------------------------------------
  logic signed [CB+NDR-1:0] dm_w[3];
  logic signed [RSW-1:0]    r_w[3];
  logic                     v4;
  side_t                    s4;
  logic signed [DMW-1:0]    dm4[3];
  logic signed [RW-1:0]     r4[3], vv4[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm_w[i] = (mdnd3[i] + (CB+NDR)'(HALF)) >>> FB;
      r_w[i]  = ((RSW'(d_c[i]) <<< FB) - (RSW'(ndn3[i]) <<< 1) + RSW'(HALF)) >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s4 <= s3;
    for (int i = 0; i < 3; i++) begin
      dm4[i] <= dm_w[i][DMW-1:0];
      r4[i]  <= r_w[i][RW-1:0];
      vv4[i] <= -RW'(po3[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: times Ld, squares of R and V
  // ---------------------------------------------------------------------
  logic                      v5;
  side_t                     s5;
  logic signed [DMW+CB-1:0]  dp5[3];
  logic signed [2*RW-1:0]    rq5[3], vq5[3];
  logic signed [RW-1:0]      r5[3], vv5[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s5 <= s4;
    for (int i = 0; i < 3; i++) begin
      dp5[i] <= dm4[i] * ld_c[i];
      rq5[i] <= r4[i] * r4[i];
      vq5[i] <= vv4[i] * vv4[i];
      r5[i]  <= r4[i];
      vv5[i] <= vv4[i];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: diffuse result, sums of squares; feeds the square root
  // Lane 0 is R, lane 1 is V.
  // ---------------------------------------------------------------------
  logic signed [DMW+CB-1:0] dif_w[3];
  side_t                    s6_w;
  logic                     sqv[NSQ+1];
  side_t                    sqs[NSQ+1];
  logic [SQW-1:0]           sqx[NSQ+1][2];
  logic [SQW-1:0]           sqr[NSQ+1][2];
  logic signed [RW-1:0]     sqc[NSQ+1][2][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif_w[i] = (dp5[i] + (DMW+CB)'(HALF)) >>> FB;
    end
    s6_w     = s5;
    s6_w.dif = pack3(sat(SATW'(dif_w[0])), sat(SATW'(dif_w[1])), sat(SATW'(dif_w[2])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else begin
      sqv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    sqs[0]     <= s6_w;
    sqx[0][0]  <= $unsigned(rq5[0]) + $unsigned(rq5[1]) + $unsigned(rq5[2]);
    sqx[0][1]  <= $unsigned(vq5[0]) + $unsigned(vq5[1]) + $unsigned(vq5[2]);
    sqr[0][0]  <= '0;
    sqr[0][1]  <= '0;
    for (int i = 0; i < 3; i++) begin
      sqc[0][0][i] <= r5[i];
      sqc[0][1][i] <= vv5[i];
    end
  end

  // ---------------------------------------------------------------------
  // Square root: one result bit per stage (digit-by-digit)
  // ---------------------------------------------------------------------
  for (genvar q = 0; q < NSQ; q++) begin : g_sqrt
    localparam logic [SQW-1:0] SBIT = SQW'(1) << (SQW - 2 - 2 * q);
    logic [SQW-1:0] t[2];
    logic           ge[2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]  = sqr[q][l] + SBIT;
        ge[l] = sqx[q][l] >= t[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[q+1] <= 1'b0;
      end else begin
        sqv[q+1] <= sqv[q];
      end
    end

    always_ff @(posedge clk) begin
      sqs[q+1] <= sqs[q];
      for (int l = 0; l < 2; l++) begin
        sqx[q+1][l] <= ge[l] ? sqx[q][l] - t[l] : sqx[q][l];
        sqr[q+1][l] <= ge[l] ? (sqr[q][l] >> 1) + SBIT : sqr[q][l] >> 1;
        for (int i = 0; i < 3; i++) begin
          sqc[q+1][l][i] <= sqc[q][l][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divider setup: magnitudes scaled by 2^FB, signs kept aside.
  // Lanes 0..2 are R components, 3..5 are V components.
  // ---------------------------------------------------------------------
  logic                 dvv[QW+1];
  side_t                dvs[QW+1];
  logic [DNW-1:0]       dvrem[QW+1][6];
  logic [QW-1:0]        dvq[QW+1][6];
  logic                 dvneg[QW+1][6];
  logic [RW-1:0]        dvlen[QW+1][2];
  logic signed [RW-1:0] mag_s[6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      mag_s[l] = sqc[NSQ][l/3][l%3][RW-1] ? -sqc[NSQ][l/3][l%3] : sqc[NSQ][l/3][l%3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= sqv[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    dvs[0]      <= sqs[NSQ];
    dvlen[0][0] <= sqr[NSQ][0][RW-1:0];
    dvlen[0][1] <= sqr[NSQ][1][RW-1:0];
    for (int l = 0; l < 6; l++) begin
      dvrem[0][l] <= DNW'($unsigned(mag_s[l])) << FB;
      dvq[0][l]   <= '0;
      dvneg[0][l] <= sqc[NSQ][l/3][l%3][RW-1];
    end
  end

  // ---------------------------------------------------------------------
  // Restoring division: one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int QB = FB - j;
    logic [DNW-1:0] t[6];
    logic           ge[6];

    always_comb begin
      for (int l = 0; l < 6; l++) begin
        t[l]  = DNW'(dvlen[j][l/3]) << QB;
        ge[l] = dvrem[j][l] >= t[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else begin
        dvv[j+1] <= dvv[j];
      end
    end

    always_ff @(posedge clk) begin
      dvs[j+1]      <= dvs[j];
      dvlen[j+1][0] <= dvlen[j][0];
      dvlen[j+1][1] <= dvlen[j][1];
      for (int l = 0; l < 6; l++) begin
        dvrem[j+1][l]     <= ge[l] ? dvrem[j][l] - t[l] : dvrem[j][l];
        dvq[j+1][l]       <= dvq[j][l] | (QW'(ge[l]) << QB);
        dvneg[j+1][l]     <= dvneg[j][l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Unit vectors and their products
  // ---------------------------------------------------------------------
  comp_t                  unit_c[6];
  logic                   v_pr;
  side_t                  s_pr;
  logic signed [2*CB-1:0] pr[3];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      if (dvlen[QW][l/3] == '0) begin
        unit_c[l] = '0;  // zero-length vector normalizes to zero
      end else if (dvneg[QW][l]) begin
        unit_c[l] = -comp_t'(dvq[QW][l]);
      end else begin
        unit_c[l] = comp_t'(dvq[QW][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pr <= 1'b0;
    end else begin
      v_pr <= dvv[QW];
    end
  end

  always_ff @(posedge clk) begin
    s_pr <= dvs[QW];
    for (int i = 0; i < 3; i++) begin
      pr[i] <= unit_c[i] * unit_c[i+3];
    end
  end

  // ---------------------------------------------------------------------
  // Cosine: sum, round, clamp to [-1, 1]; feeds the power chain
  // ---------------------------------------------------------------------
  logic signed [2*CB+1:0] cs_w;
  comp_t                  cos_c;
  logic                   pwv[KMAX+1];
  side_t                  pws[KMAX+1];
  comp_t                  pwc[KMAX+1];
  comp_t                  pwp[KMAX+1];

  always_comb begin
    cs_w = ((2*CB+2)'(pr[0]) + (2*CB+2)'(pr[1]) + (2*CB+2)'(pr[2])
            + (2*CB+2)'(HALF)) >>> FB;
    if (cs_w > (2*CB+2)'(ONE)) begin
      cos_c = comp_t'(ONE);
    end else if (cs_w < -(2*CB+2)'(ONE)) begin
      cos_c = -comp_t'(ONE);
    end else begin
      cos_c = cs_w[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwv[0] <= 1'b0;
    end else begin
      pwv[0] <= v_pr;
    end
  end

  always_ff @(posedge clk) begin
    pws[0] <= s_pr;
    pwc[0] <= cos_c;
    pwp[0] <= comp_t'(ONE);
  end

  // ---------------------------------------------------------------------
  // Power: step j multiplies by the cosine when j < k, else passes through
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < KMAX; j++) begin : g_pow
    logic signed [2*CB-1:0] m;

    always_comb begin
      m = (pwp[j] * pwc[j] + (2*CB)'(HALF)) >>> FB;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pwv[j+1] <= 1'b0;
      end else begin
        pwv[j+1] <= pwv[j];
      end
    end

    always_ff @(posedge clk) begin
      pws[j+1] <= pws[j];
      pwc[j+1] <= pwc[j];
      pwp[j+1] <= (KW'(j) < pws[j].k) ? m[CB-1:0] : pwp[j];
    end
  end

  // ---------------------------------------------------------------------
  // Specular: Ms * p, round, times Ls
  // ---------------------------------------------------------------------
  logic                   va, vb;
  side_t                  sa, sb;
  logic signed [2*CB-1:0] ma_p[3], mr_w[3];
  logic signed [2*CB+1:0] mb_p[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= pwv[KMAX];
      vb <= va;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mr_w[i] = (ma_p[i] + (2*CB)'(HALF)) >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    sa <= pws[KMAX];
    sb <= sa;
    for (int i = 0; i < 3; i++) begin
      ma_p[i] <= comp_of(pws[KMAX].ms, i) * pwp[KMAX];
      mb_p[i] <= $signed(mr_w[i][CB+1:0]) * ls_c[i];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic signed [2*CB+1:0] sp_w[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp_w[i] = (mb_p[i] + (2*CB+2)'(HALF)) >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
  end

  always_ff @(posedge clk) begin
    ambient_out     <= sb.amb;
    diffuse_out     <= sb.dif;
    specular_culled <= sb.culled;
    specular_out    <= sb.culled ? '0 :
                       pack3(sat(SATW'(sp_w[0])), sat(SATW'(sp_w[1])), sat(SATW'(sp_w[2])));
  end

endmodule
